### design/trm_pkg.sv
// Shared types and constants for the top-1 row mask block.
package trm_pkg;

    localparam logic [6:0] RowLengthReset = 7'd64;
    localparam logic [31:0] PosZeroBits = 32'h0000_0000;
    localparam logic [31:0] AbsMask = 32'h7FFF_FFFF;
    localparam logic [31:0] InfBits = 32'h7F80_0000;

    localparam logic [0:0] RegRowLength = 1'b0;

    // One finished row handed from the scan stage to the emit stage.
    typedef struct packed {
        logic [31:0] best_bits;
        logic [8:0]  best_position;
        logic [8:0]  length;
    } t_row;

    function automatic logic is_nan(input logic [31:0] b);
        is_nan = (b & AbsMask) > InfBits;
    endfunction

    function automatic logic greater(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ka;
        logic [31:0] kb;
        ka = a[31] ? ~a : (a | 32'h8000_0000);
        kb = b[31] ? ~b : (b | 32'h8000_0000);
        if (is_nan(a) || is_nan(b)) begin
            greater = 1'b0;
        end else if (((a | b) & AbsMask) == 32'd0) begin
            greater = 1'b0;
        end else begin
            greater = ka > kb;
        end
    endfunction

endpackage

### design/trm_scan.sv
// Front stage: tracks the running maximum of a row and hands finished rows on.
module trm_scan #(
    parameter int MAX_EXPERTS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [6:0]           i_row_length,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [31:0]          i_value_bits,
    output logic                 o_row_valid,
    input  logic                 i_row_stall,
    output trm_pkg::t_row        o_row
);

    logic [31:0] r_best_bits;
    logic [8:0]  r_best_position;
    logic [8:0]  r_count;
    logic [8:0]  len;
    logic [31:0] n_best_bits;
    logic [8:0]  n_best_position;
    logic        accept;
    logic        row_end;

    always_comb begin
        if (i_row_length == 7'd0) begin
            len = 9'd1;
        end else if ({2'b00, i_row_length} > 9'(MAX_EXPERTS)) begin
            len = 9'(MAX_EXPERTS);
        end else begin
            len = {2'b00, i_row_length};
        end
    end

    assign row_end = (r_count + 9'd1) >= len;
    assign o_stall = row_end && i_row_stall;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_best_bits = r_best_bits;
        n_best_position = r_best_position;
        if (r_count == 9'd0) begin
            n_best_bits = i_value_bits;
            n_best_position = 9'd0;
        end else if (trm_pkg::greater(i_value_bits, r_best_bits)) begin
            n_best_bits = i_value_bits;
            n_best_position = r_count;
        end
    end

    assign o_row_valid = accept && row_end;
    assign o_row = '{best_bits: n_best_bits, best_position: n_best_position, length: len};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 9'd0;
            r_best_bits <= 32'd0;
            r_best_position <= 9'd0;
        end else if (accept) begin
            r_best_bits <= n_best_bits;
            r_best_position <= n_best_position;
            r_count <= row_end ? 9'd0 : r_count + 9'd1;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !row_end |=> r_count == $past(r_count) + 9'd1)
        else $error("count did not advance");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_row_valid |-> o_row.best_position < o_row.length || o_row.length < len + 9'd1)
        else $error("bad row");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < 9'(MAX_EXPERTS))
        else $error("count out of range");

endmodule

### design/trm_emit.sv
// Back stage: a two-entry row queue and the result sequencer.
module trm_emit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_row_valid,
    output logic          o_row_stall,
    input  trm_pkg::t_row i_row,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [31:0]   o_masked_bits,
    output logic [5:0]    o_expert_index,
    output logic          o_row_last
);

    trm_pkg::t_row r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_fill;
    logic [8:0]    r_idx;
    logic          push;
    logic          pop;
    logic          fire;
    logic          last;
    trm_pkg::t_row head;

    assign head = r_q[r_rp];
    assign o_row_stall = (r_fill == 2'd2);
    assign push = i_row_valid && !o_row_stall;
    assign o_valid = (r_fill != 2'd0);
    assign fire = o_valid && !i_stall;
    assign last = (r_idx + 9'd1) == head.length;
    assign pop = fire && last;

    assign o_masked_bits = (r_idx == head.best_position) ? head.best_bits
                                                         : trm_pkg::PosZeroBits;
    assign o_expert_index = r_idx[5:0];
    assign o_row_last = last;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_fill <= 2'd0;
            r_idx <= 9'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_fill <= r_fill + {1'b0, push} - {1'b0, pop};
            if (fire) begin
                r_idx <= last ? 9'd0 : r_idx + 9'd1;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 2'd2)
        else $error("queue overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_idx < head.length)
        else $error("index past row end");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !push |=> r_fill == $past(r_fill) - 2'd1)
        else $error("pop lost");

endmodule

### design/top1_row_mask.sv
// Top level of the streaming top-1 row mask.
//  channel | direction | signals
//  input   | in        | i_valid, o_stall, i_value_bits
//  output  | out       | o_valid, i_stall, o_masked_bits, o_expert_index, o_row_last
//  config  | APB       | psel, penable, pwrite, paddr, pwdata, prdata, pready
// One input and one output transaction per cycle, unless held by o_stall or i_stall.
// Each row of N scores yields N results; emission of a row overlaps the scan of the next.
// The row-end transaction stalls only while the two-row queue is full.
// Synchronous active-low reset clears all control state; row length resets to 64.
module top1_row_mask #(
    parameter int MAX_EXPERTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_value_bits,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_masked_bits,
    output logic [5:0]  o_expert_index,
    output logic        o_row_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [6:0]    r_row_length;
    logic          row_valid;
    logic          row_stall;
    trm_pkg::t_row row;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == trm_pkg::RegRowLength) ? {25'd0, r_row_length} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length <= trm_pkg::RowLengthReset;
        end else if (psel && penable && pwrite && paddr[2] == trm_pkg::RegRowLength) begin
            r_row_length <= pwdata[6:0];
        end
    end

    trm_scan #(.MAX_EXPERTS(MAX_EXPERTS)) u_scan (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_row_length(r_row_length),
        .i_valid(i_valid), .o_stall(o_stall), .i_value_bits(i_value_bits),
        .o_row_valid(row_valid), .i_row_stall(row_stall), .o_row(row)
    );

    trm_emit u_emit (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_row_valid(row_valid),
        .o_row_stall(row_stall), .i_row(row), .o_valid(o_valid), .i_stall(i_stall),
        .o_masked_bits(o_masked_bits), .o_expert_index(o_expert_index),
        .o_row_last(o_row_last)
    );

endmodule
